// ===== src/accumulator_machine_core_assert.svh =====
// Assertion macros used by the checker of the accumulator machine
`ifndef ACCUMULATOR_MACHINE_CORE_ASSERT_SVH
`define ACCUMULATOR_MACHINE_CORE_ASSERT_SVH

// Same-cycle implication, sampled on clk, quiet while rst_n is low
`define ACM_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("accumulator machine check failed");

// Next-cycle implication, sampled on clk, quiet while rst_n is low
`define ACM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("accumulator machine check failed");

`endif

// ===== src/acm_pkg.sv =====
package acm_pkg;

  localparam int MEM_WORDS_DEF = 1000;

  localparam int WORD_MIN = -9999;
  localparam int WORD_MAX = 9999;
  localparam int READ_MAX = 9998;

  // Result status codes
  localparam logic [3:0] ST_RAN         = 4'd0;
  localparam logic [3:0] ST_HALT        = 4'd1;
  localparam logic [3:0] ST_BAD_OP      = 4'd2;
  localparam logic [3:0] ST_BAD_OPERAND = 4'd3;
  localparam logic [3:0] ST_BAD_COUNTER = 4'd4;
  localparam logic [3:0] ST_OVERFLOW    = 4'd5;
  localparam logic [3:0] ST_DIV_ZERO    = 4'd6;
  localparam logic [3:0] ST_BAD_INPUT   = 4'd7;
  localparam logic [3:0] ST_NEG_EXP     = 4'd8;
  localparam logic [3:0] ST_WAIT        = 4'd9;

  // Print kinds
  localparam logic [1:0] PK_NONE    = 2'd0;
  localparam logic [1:0] PK_NUMBER  = 2'd1;
  localparam logic [1:0] PK_NEWLINE = 2'd2;

  // Request kinds
  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_STEP = 1'b1;

  // Opcodes (word divided by 100)
  localparam logic [7:0] OP_READ    = 8'd10;
  localparam logic [7:0] OP_WRITE   = 8'd11;
  localparam logic [7:0] OP_NEWLINE = 8'd12;
  localparam logic [7:0] OP_LOAD    = 8'd20;
  localparam logic [7:0] OP_STORE   = 8'd21;
  localparam logic [7:0] OP_ADD     = 8'd30;
  localparam logic [7:0] OP_SUB     = 8'd31;
  localparam logic [7:0] OP_DIV     = 8'd32;
  localparam logic [7:0] OP_MUL     = 8'd33;
  localparam logic [7:0] OP_MOD     = 8'd34;
  localparam logic [7:0] OP_POW     = 8'd35;
  localparam logic [7:0] OP_BRANCH  = 8'd40;
  localparam logic [7:0] OP_BRNEG   = 8'd41;
  localparam logic [7:0] OP_BRZERO  = 8'd42;
  localparam logic [7:0] OP_HALT    = 8'd43;

  // Reciprocal of 100 scaled by 2^19, exact for values below 43699
  localparam logic [12:0] RECIP100    = 13'd5243;
  localparam int          RECIP_SHIFT = 19;

  typedef logic signed [14:0] word_t;

  function automatic logic word_ok(input logic signed [31:0] v);
    return (v >= WORD_MIN) && (v <= WORD_MAX);
  endfunction

  function automatic logic read_ok(input logic signed [31:0] v);
    return (v >= WORD_MIN) && (v <= READ_MAX);
  endfunction

endpackage

// ===== src/acm_mem.sv =====
module acm_mem #(
  parameter int MEM_WORDS = acm_pkg::MEM_WORDS_DEF
) (
  input  logic                         clk,
  input  logic                         we,
  input  logic [$clog2(MEM_WORDS)-1:0] waddr,
  input  acm_pkg::word_t               wdata,
  input  logic [$clog2(MEM_WORDS)-1:0] raddr,
  output acm_pkg::word_t               rdata
);
  import acm_pkg::*;

  word_t mem [MEM_WORDS];
  word_t rdata_r;

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== src/acm_div.sv =====
module acm_div (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  input  acm_pkg::word_t dividend,
  input  acm_pkg::word_t divisor,
  output logic           done,
  output acm_pkg::word_t quotient,
  output acm_pkg::word_t remainder
);
  import acm_pkg::*;

  logic        run_r;
  logic        done_r;
  logic [3:0]  step_r;
  logic [14:0] q_r;
  logic [15:0] r_r;
  logic [14:0] d_r;
  logic        negq_r;
  logic        negr_r;
  logic [15:0] r_sh;
  logic [16:0] diff;

  // Shift in one dividend bit, trial subtract
  assign r_sh = {r_r[14:0], q_r[14]};
  assign diff = {1'b0, r_sh} - {2'b00, d_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r  <= 1'b1;
        step_r <= '0;
        q_r    <= dividend[14] ? 15'(-dividend) : 15'(dividend);
        d_r    <= divisor[14] ? 15'(-divisor) : 15'(divisor);
        r_r    <= '0;
        negq_r <= dividend[14] ^ divisor[14];
        negr_r <= dividend[14];
      end else if (run_r) begin
        if (!diff[16]) begin
          r_r <= diff[15:0];
          q_r <= {q_r[13:0], 1'b1};
        end else begin
          r_r <= r_sh;
          q_r <= {q_r[13:0], 1'b0};
        end
        step_r <= step_r + 4'd1;
        if (step_r == 4'd14) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Apply signs, truncating toward zero
  assign done      = done_r;
  assign quotient  = negq_r ? word_t'(-q_r) : word_t'(q_r);
  assign remainder = negr_r ? word_t'(-r_r[14:0]) : word_t'(r_r[14:0]);

endmodule

// ===== src/accumulator_machine_core.sv =====
// Decimal accumulator machine. Raise start with a request while busy is low;
// exactly one result follows, shown for a single cycle with out_valid high,
// and it cannot be held off, so capture it on that cycle. The word memory
// has a registered read port, so an instruction step reads the fetched
// word first and then its operand. Divide and modulo use a 15-step
// shift-subtract divider, and power repeats the multiply. After reset the
// block stays busy while it sweeps zeros through the word memory.
module accumulator_machine_core #(
  parameter int MEM_WORDS = acm_pkg::MEM_WORDS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  logic                  in_cmd,
  input  logic [9:0]            in_load_address,
  input  logic signed [14:0]    in_data_word,
  input  logic                  in_data_valid,
  output logic                  out_valid,
  output logic [3:0]            out_status,
  output logic [1:0]            out_print_kind,
  output logic signed [14:0]    out_print_value,
  output logic signed [14:0]    out_acc_value,
  output logic [9:0]            out_counter_value,
  output logic [31:0]           out_executed_count
);
  import acm_pkg::*;

  localparam int AW = $clog2(MEM_WORDS);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_FETCH, S_DECODE, S_EXEC, S_MUL, S_DIV, S_POWMUL, S_POWCHK, S_DONE
  } state_t;

  state_t      state_r;
  logic [AW-1:0] clr_r;
  word_t       acc_r;
  logic [9:0]  pc_r;
  logic [3:0]  halt_r;
  logic [31:0] cnt_r;
  logic [3:0]  st_r;
  logic [1:0]  kind_r;
  word_t       pv_r;
  word_t       data_r;
  logic        dvalid_r;
  logic        neg_r;
  logic [14:0] abs_r;
  logic [7:0]  q_r;
  logic [6:0]  opnd_r;
  logic [29:0] prod_r;
  word_t       pow_r;
  logic [13:0] powm_r;
  logic [13:0] powk_r;

  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  word_t         mem_wdata;
  logic [AW-1:0] mem_raddr;
  word_t         mem_rdata;

  logic          div_start;
  logic          div_done;
  word_t         div_q;
  word_t         div_r;

  logic [14:0] w_abs;
  logic [27:0] w_recip;
  logic [14:0] rem_full;
  logic [6:0]  rem;
  word_t       mul_x;
  logic signed [29:0] mul_p;
  logic signed [15:0] sum_add;
  logic signed [15:0] sum_sub;
  logic [9:0]  pc_inc;
  logic        load_ok;

  acm_mem #(.MEM_WORDS(MEM_WORDS)) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  acm_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (acc_r),
    .divisor   (mem_rdata),
    .done      (div_done),
    .quotient  (div_q),
    .remainder (div_r)
  );

  // Split the fetched word by 100: quotient by reciprocal, remainder next cycle
  assign w_abs    = mem_rdata[14] ? 15'(-mem_rdata) : 15'(mem_rdata);
  assign w_recip  = w_abs * RECIP100;
  assign rem_full = abs_r - (({7'b0, q_r} << 6) + ({7'b0, q_r} << 5) + ({7'b0, q_r} << 2));
  assign rem      = rem_full[6:0];

  // One shared multiplier for multiply and power
  assign mul_x   = (state_r == S_POWMUL) ? pow_r : mem_rdata;
  assign mul_p   = mul_x * acc_r;
  assign sum_add = 16'(acc_r) + 16'(mem_rdata);
  assign sum_sub = 16'(acc_r) - 16'(mem_rdata);
  assign pc_inc  = pc_r + 10'd1;

  assign load_ok = (32'(in_load_address) < MEM_WORDS) && read_ok(32'(in_data_word));

  // Memory port steering
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = clr_r;
    mem_wdata = '0;
    mem_raddr = pc_r[AW-1:0];
    unique case (state_r)
      S_CLEAR: begin
        mem_we = 1'b1;
      end
      S_IDLE: begin
        if (start && in_cmd == CMD_LOAD && load_ok) begin
          mem_we    = 1'b1;
          mem_waddr = in_load_address[AW-1:0];
          mem_wdata = in_data_word;
        end
      end
      S_DECODE: begin
        mem_raddr = AW'(rem);
      end
      S_EXEC: begin
        mem_waddr = AW'(opnd_r);
        if (!neg_r && q_r == OP_READ && read_ok(32'(data_r))) begin
          mem_we    = 1'b1;
          mem_wdata = data_r;
        end else if (!neg_r && q_r == OP_STORE) begin
          mem_we    = 1'b1;
          mem_wdata = acc_r;
        end
      end
      default: ;
    endcase
  end

  assign div_start = (state_r == S_EXEC) && !neg_r && (q_r == OP_DIV || q_r == OP_MOD)
                     && (mem_rdata != '0);

  // Sequencer: clear, then fetch, decode, execute, report
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      clr_r   <= '0;
      acc_r   <= '0;
      pc_r    <= '0;
      halt_r  <= ST_RAN;
      cnt_r   <= '0;
      st_r    <= ST_RAN;
      kind_r  <= PK_NONE;
      pv_r    <= '0;
    end else begin
      unique case (state_r)
        S_CLEAR: begin
          clr_r <= clr_r + AW'(1);
          if (32'(clr_r) == MEM_WORDS - 1) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          kind_r <= PK_NONE;
          pv_r   <= '0;
          if (start) begin
            data_r   <= in_data_word;
            dvalid_r <= in_data_valid;
            if (in_cmd == CMD_LOAD || halt_r != ST_RAN) begin
              st_r    <= halt_r;
              state_r <= S_DONE;
            end else if (32'(pc_r) >= MEM_WORDS) begin
              halt_r  <= ST_BAD_COUNTER;
              st_r    <= ST_BAD_COUNTER;
              state_r <= S_DONE;
            end else begin
              state_r <= S_FETCH;
            end
          end
        end
        S_FETCH: begin
          neg_r   <= mem_rdata[14];
          abs_r   <= w_abs;
          q_r     <= w_recip[RECIP_SHIFT+7:RECIP_SHIFT];
          state_r <= S_DECODE;
        end
        S_DECODE: begin
          opnd_r <= rem;
          // negative word with a remainder gives a negative operand
          if (neg_r && rem != '0) begin
            halt_r  <= ST_BAD_OPERAND;
            st_r    <= ST_BAD_OPERAND;
            state_r <= S_DONE;
          end else if (!neg_r && q_r == OP_READ && !dvalid_r) begin
            st_r    <= ST_WAIT;
            state_r <= S_DONE;
          end else begin
            if (cnt_r != '1) begin
              cnt_r <= cnt_r + 32'd1;
            end
            state_r <= S_EXEC;
          end
        end
        S_EXEC: begin
          st_r    <= ST_RAN;
          state_r <= S_DONE;
          pc_r    <= pc_inc;
          if (neg_r) begin
            halt_r <= ST_BAD_OP;
            st_r   <= ST_BAD_OP;
            pc_r   <= pc_r;
          end else begin
            unique case (q_r)
              OP_READ: begin
                if (!read_ok(32'(data_r))) begin
                  halt_r <= ST_BAD_INPUT;
                  st_r   <= ST_BAD_INPUT;
                  pc_r   <= pc_r;
                end
              end
              OP_WRITE: begin
                kind_r <= PK_NUMBER;
                pv_r   <= mem_rdata;
              end
              OP_NEWLINE: kind_r <= PK_NEWLINE;
              OP_LOAD:    acc_r  <= mem_rdata;
              OP_STORE:   ;
              OP_ADD, OP_SUB: begin
                if (!word_ok(32'(q_r == OP_ADD ? sum_add : sum_sub))) begin
                  halt_r <= ST_OVERFLOW;
                  st_r   <= ST_OVERFLOW;
                  pc_r   <= pc_r;
                end else begin
                  acc_r <= q_r == OP_ADD ? sum_add[14:0] : sum_sub[14:0];
                end
              end
              OP_MUL: begin
                prod_r  <= mul_p;
                pc_r    <= pc_r;
                state_r <= S_MUL;
              end
              OP_DIV, OP_MOD: begin
                pc_r <= pc_r;
                if (mem_rdata == '0) begin
                  halt_r <= ST_DIV_ZERO;
                  st_r   <= ST_DIV_ZERO;
                end else begin
                  state_r <= S_DIV;
                end
              end
              OP_POW: begin
                if (mem_rdata[14]) begin
                  halt_r <= ST_NEG_EXP;
                  st_r   <= ST_NEG_EXP;
                  pc_r   <= pc_r;
                end else if (mem_rdata == '0) begin
                  acc_r <= word_t'(1);
                end else if (acc_r == word_t'(-1)) begin
                  acc_r <= mem_rdata[0] ? word_t'(-1) : word_t'(1);
                end else if (acc_r == '0 || acc_r == word_t'(1)) begin
                  acc_r <= acc_r;
                end else begin
                  // magnitude two or more: an exponent of 14 or more overflows within 14 multiplies
                  pow_r   <= word_t'(1);
                  powm_r  <= mem_rdata[13:0];
                  powk_r  <= '0;
                  pc_r    <= pc_r;
                  state_r <= S_POWMUL;
                end
              end
              OP_BRANCH: pc_r <= 10'(opnd_r);
              OP_BRNEG:  if (acc_r[14]) pc_r <= 10'(opnd_r);
              OP_BRZERO: if (acc_r == '0) pc_r <= 10'(opnd_r);
              OP_HALT: begin
                halt_r <= ST_HALT;
                st_r   <= ST_HALT;
                pc_r   <= pc_r;
              end
              default: begin
                halt_r <= ST_BAD_OP;
                st_r   <= ST_BAD_OP;
                pc_r   <= pc_r;
              end
            endcase
          end
        end
        S_MUL: begin
          state_r <= S_DONE;
          if (!word_ok(32'($signed(prod_r)))) begin
            halt_r <= ST_OVERFLOW;
            st_r   <= ST_OVERFLOW;
          end else begin
            acc_r <= prod_r[14:0];
            pc_r  <= pc_inc;
          end
        end
        S_DIV: begin
          if (div_done) begin
            acc_r   <= (q_r == OP_DIV) ? div_q : div_r;
            pc_r    <= pc_inc;
            state_r <= S_DONE;
          end
        end
        S_POWMUL: begin
          prod_r  <= mul_p;
          powk_r  <= powk_r + 14'd1;
          state_r <= S_POWCHK;
        end
        S_POWCHK: begin
          if (!word_ok(32'($signed(prod_r)))) begin
            halt_r  <= ST_OVERFLOW;
            st_r    <= ST_OVERFLOW;
            state_r <= S_DONE;
          end else if (powk_r == powm_r) begin
            acc_r   <= prod_r[14:0];
            pc_r    <= pc_inc;
            state_r <= S_DONE;
          end else begin
            pow_r   <= prod_r[14:0];
            state_r <= S_POWMUL;
          end
        end
        S_DONE: begin
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // Present the result from the state registers
  assign busy               = (state_r != S_IDLE);
  assign out_valid          = (state_r == S_DONE);
  assign out_status         = st_r;
  assign out_print_kind     = kind_r;
  assign out_print_value    = pv_r;
  assign out_acc_value      = acc_r;
  assign out_counter_value  = pc_r;
  assign out_executed_count = cnt_r;

endmodule

// ===== src/acm_checker.sv =====
`include "accumulator_machine_core_assert.svh"

module acm_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        start,
  input logic        busy,
  input logic        out_valid,
  input logic [3:0]  out_status,
  input logic [1:0]  out_print_kind,
  input logic [14:0] out_print_value,
  input logic [31:0] out_executed_count
);
  import acm_pkg::*;

  // A result strobe lasts one cycle
  `ACM_ASSERT_NEXT(a_strobe_single, out_valid, !out_valid)

  // An accepted request sets busy
  `ACM_ASSERT_NEXT(a_accept_busy, start && !busy, busy)

  // Halting results never print
  `ACM_ASSERT_NOW(a_halt_quiet, out_valid && out_status != ST_RAN && out_status != ST_WAIT, out_print_kind == PK_NONE)

  // Print value is zero unless a number is printed
  `ACM_ASSERT_NOW(a_pv_zero, out_valid && out_print_kind != PK_NUMBER, out_print_value == '0)

  // Idle without a request leaves the count alone
  `ACM_ASSERT_NEXT(a_cnt_hold, !busy && !start, $stable(out_executed_count))

endmodule

bind accumulator_machine_core acm_checker u_acm_checker (.*);
